FILE: design/dsl_pkg.sv
// types and constants shared by the differenced, smoothed, lagged feature stream
// no dependencies
`default_nettype none

package dsl_pkg;

  localparam int SUM_W       = 37;
  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STEPS   = SUM_W;

  localparam logic [2:0] CFG_DIFF_LAG      = 3'd0;
  localparam logic [2:0] CFG_SMOOTH_LEN    = 3'd1;
  localparam logic [2:0] CFG_LAG_COUNT     = 3'd2;
  localparam logic [2:0] CFG_SAMPLE_CUTOFF = 3'd3;
  localparam logic [2:0] CFG_PREDICT_MODE  = 3'd4;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // effective settings after saturation
  typedef struct packed {
    logic [3:0]  dl;
    logic [4:0]  sl;
    logic [4:0]  win;
    logic [31:0] cutoff;
    logic        predict;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic        clear;
    logic        have_d;
    logic [15:0] diffs;
    logic [32:0] d;
    logic [31:0] rand_word;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: design/diff_smooth_lag_feature_stream.sv
// top level: configuration registers, front, command queue and back
// depends on dsl_pkg, dsl_front, dsl_cmd_fifo, dsl_back
//
//   channel   handshake        payload
//   input     push / full      raw_value, rand_word, series_start
//   result    empty / pop      feature_value, element_index, window_index, window_last
//   config    cfg_write        cfg_index, cfg_data
//
// the front takes one item per cycle, unless full, into a four-deep command queue
// the back takes an item while idle; an item that forms no mean goes straight back
// to idle, else it sums the span, runs a 37-step serial divide and, if due, emits
// the window elements through the output register, which holds until popped
// reset is synchronous and clears all series state at once
`default_nettype none

module diff_smooth_lag_feature_stream #(
  parameter int MAX_DIFF_LAG   = 8,
  parameter int MAX_SMOOTH_LEN = 16,
  parameter int MAX_WINDOW     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] raw_value,
  input  wire logic [31:0] rand_word,
  input  wire logic        series_start,
  output logic             empty,
  input  wire logic        pop,
  output logic [32:0]      feature_value,
  output logic [3:0]       element_index,
  output logic [15:0]      window_index,
  output logic             window_last,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import dsl_pkg::*;

  logic [3:0]  diff_lag;
  logic [4:0]  smooth_len;
  logic [3:0]  lag_count;
  logic [31:0] sample_cutoff;
  logic        predict_mode;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_empty;
  logic q_pop;
  logic [4:0] sl_min1;
  logic [4:0] win_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_lag      <= 4'd1;
      smooth_len    <= 5'd3;
      lag_count     <= 4'd5;
      sample_cutoff <= 32'hFFFF_FFFF;
      predict_mode  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIFF_LAG:      diff_lag      <= cfg_data[3:0];
        CFG_SMOOTH_LEN:    smooth_len    <= cfg_data[4:0];
        CFG_LAG_COUNT:     lag_count     <= cfg_data[3:0];
        CFG_SAMPLE_CUTOFF: sample_cutoff <= cfg_data;
        CFG_PREDICT_MODE:  predict_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sl_min1     = (smooth_len == 5'd0) ? 5'd1 : smooth_len;
    win_raw     = 5'(lag_count) + 5'd1;
    cfg.dl      = (32'(diff_lag) > MAX_DIFF_LAG) ? 4'(MAX_DIFF_LAG) : diff_lag;
    cfg.sl      = (32'(sl_min1) > MAX_SMOOTH_LEN) ? 5'(MAX_SMOOTH_LEN) : sl_min1;
    cfg.win     = (32'(win_raw) > MAX_WINDOW) ? 5'(MAX_WINDOW) : win_raw;
    cfg.cutoff  = sample_cutoff;
    cfg.predict = predict_mode;
  end

  dsl_front #(
    .MAX_DIFF_LAG (MAX_DIFF_LAG)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (push && !full),
    .raw_value    (raw_value),
    .rand_word    (rand_word),
    .series_start (series_start),
    .cfg          (cfg),
    .cmd          (front_cmd)
  );

  dsl_cmd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (q_pop),
    .rdata (back_cmd),
    .empty (q_empty)
  );

  dsl_back #(
    .MAX_SMOOTH_LEN (MAX_SMOOTH_LEN),
    .MAX_WINDOW     (MAX_WINDOW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (back_cmd),
    .cmd_empty     (q_empty),
    .cmd_pop       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .feature_value (feature_value),
    .element_index (element_index),
    .window_index  (window_index),
    .window_last   (window_last)
  );

endmodule

`default_nettype wire

FILE: design/dsl_cmd_fifo.sv
// short command queue between front and back
// depends on dsl_pkg
`default_nettype none

module dsl_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  dsl_pkg::cmd_t      wdata,
  output logic               full,
  input  wire logic          pop,
  output dsl_pkg::cmd_t      rdata,
  output logic               empty
);
  import dsl_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        entries[wr_ptr] <= wdata;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/dsl_front.sv
// front part: raw sample history, difference and item classification
// depends on dsl_pkg
`default_nettype none

module dsl_front #(
  parameter int MAX_DIFF_LAG = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [31:0]   raw_value,
  input  wire logic [31:0]   rand_word,
  input  wire logic          series_start,
  input  dsl_pkg::cfg_t      cfg,
  output dsl_pkg::cmd_t      cmd
);
  import dsl_pkg::*;

  localparam int RIW = (MAX_DIFF_LAG > 1) ? $clog2(MAX_DIFF_LAG) : 1;

  logic [31:0]  raw_hist [MAX_DIFF_LAG];
  logic [15:0]  sample_count;
  logic [15:0]  count_cur;
  logic [15:0]  count_next;
  logic [31:0]  tap_sel;
  logic [31:0]  past;

  always_comb begin
    count_cur  = series_start ? 16'd0 : sample_count;
    count_next = (count_cur != COUNT_MAX) ? count_cur + 16'd1 : count_cur;
    tap_sel    = 32'(cfg.dl) - 32'd1;
    past       = series_start ? 32'd0 : raw_hist[tap_sel[RIW-1:0]];

    cmd.clear     = series_start;
    cmd.have_d    = (count_cur >= 16'(cfg.dl));
    cmd.diffs     = count_next - 16'(cfg.dl);
    cmd.rand_word = rand_word;
    if (cfg.dl == 4'd0) begin
      cmd.d = {raw_value[31], raw_value};
    end else begin
      cmd.d = {raw_value[31], raw_value} - {past[31], past};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      for (int i = 0; i < MAX_DIFF_LAG; i++) raw_hist[i] <= '0;
    end else if (accept) begin
      sample_count <= count_next;
      raw_hist[0]  <= raw_value;
      for (int i = 1; i < MAX_DIFF_LAG; i++) begin
        raw_hist[i] <= series_start ? 32'd0 : raw_hist[i-1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/dsl_back.sv
// back part: span sum, serial divide, smoothed window and element emission
// depends on dsl_pkg
`default_nettype none

module dsl_back #(
  parameter int MAX_SMOOTH_LEN = 16,
  parameter int MAX_WINDOW     = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  dsl_pkg::cfg_t      cfg,
  input  dsl_pkg::cmd_t      cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [32:0]        feature_value,
  output logic [3:0]         element_index,
  output logic [15:0]        window_index,
  output logic               window_last
);
  import dsl_pkg::*;

  localparam int DIW = (MAX_SMOOTH_LEN > 1) ? $clog2(MAX_SMOOTH_LEN) : 1;
  localparam int SWW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  state_t state, state_next;

  logic [32:0]      diff_hist [MAX_SMOOTH_LEN];
  logic [32:0]      smooth_win [MAX_WINDOW];
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] quo;
  logic [6:0]       rem;
  logic             neg;
  logic [5:0]       step;
  logic [DIW-1:0]   k;
  logic [3:0]       elem;
  logic [15:0]      diffs;
  logic [31:0]      rw;
  logic [15:0]      windows_seen;
  logic             first_window_done;
  logic [15:0]      widx;
  logic             out_valid;

  logic [SUM_W-1:0] acc_next;
  logic             sum_last;
  logic [6:0]       rem_sh;
  logic             q_bit;
  logic [SUM_W-1:0] mean_full;
  logic             have_win;
  logic             emit;
  logic [31:0]      rd_sel;
  logic             out_load;
  logic             emit_last;

  always_comb begin
    acc_next  = acc + {{(SUM_W-33){diff_hist[k][32]}}, diff_hist[k]};
    sum_last  = (32'(k) + 32'd1 >= 32'(cfg.sl));
    rem_sh    = {rem[5:0], quo[SUM_W-1]};
    q_bit     = (rem_sh >= 7'(cfg.sl));
    mean_full = neg ? (~quo + 1'b1) : quo;
    have_win  = (17'(diffs) + 17'd1 >= 17'(cfg.win) + 17'(cfg.sl));
    emit      = cfg.predict ? !first_window_done : (rw <= cfg.cutoff);
    rd_sel    = 32'(cfg.win) - 32'd1 - 32'(elem);
    emit_last = (5'(elem) + 5'd1 == cfg.win);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty && cmd.have_d && (cmd.diffs >= 16'(cfg.sl))) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (sum_last) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step == 6'(DIV_STEPS - 1)) state_next = ST_FIX;
      end
      ST_FIX: begin
        state_next = (have_win && emit) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop  = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: cmd_pop  = !cmd_empty;
      ST_EMIT: out_load = !out_valid || pop;
      default: begin
        cmd_pop  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      windows_seen      <= '0;
      first_window_done <= 1'b0;
      out_valid         <= 1'b0;
      for (int i = 0; i < MAX_SMOOTH_LEN; i++) diff_hist[i] <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) smooth_win[i] <= '0;
    end else begin
      state <= state_next;
      // a load in the emit state refills the output register instead
      if (pop && out_valid && !out_load) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            diffs <= cmd.diffs;
            rw    <= cmd.rand_word;
            acc   <= '0;
            k     <= '0;
            if (cmd.clear) begin
              windows_seen      <= '0;
              first_window_done <= 1'b0;
              for (int i = 0; i < MAX_WINDOW; i++) smooth_win[i] <= '0;
            end
            if (cmd.have_d) begin
              diff_hist[0] <= cmd.d;
              for (int i = 1; i < MAX_SMOOTH_LEN; i++) begin
                diff_hist[i] <= cmd.clear ? 33'd0 : diff_hist[i-1];
              end
            end else if (cmd.clear) begin
              for (int i = 0; i < MAX_SMOOTH_LEN; i++) diff_hist[i] <= '0;
            end
          end
        end
        ST_SUM: begin
          acc <= acc_next;
          k   <= k + 1'b1;
          if (sum_last) begin
            neg  <= acc_next[SUM_W-1];
            quo  <= acc_next[SUM_W-1] ? (~acc_next + 1'b1) : acc_next;
            rem  <= '0;
            step <= '0;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem  <= q_bit ? (rem_sh - 7'(cfg.sl)) : rem_sh;
          quo  <= {quo[SUM_W-2:0], q_bit};
          step <= step + 1'b1;
        end
        ST_FIX: begin
          smooth_win[0] <= mean_full[32:0];
          for (int i = 1; i < MAX_WINDOW; i++) smooth_win[i] <= smooth_win[i-1];
          if (have_win) begin
            if (cfg.predict) first_window_done <= 1'b1;
            widx <= windows_seen;
            elem <= '0;
            if (windows_seen != COUNT_MAX) windows_seen <= windows_seen + 16'd1;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid     <= 1'b1;
            feature_value <= smooth_win[rd_sel[SWW-1:0]];
            element_index <= elem;
            window_index  <= widx;
            window_last   <= emit_last;
            elem          <= elem + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/diff_smooth_lag_feature_stream_tb.sv
// testbench for the differenced, smoothed, lagged feature stream
// drives items through push/full, checks every window element popped against a model
// depends on dsl_pkg and diff_smooth_lag_feature_stream
`timescale 1ns / 100ps

module diff_smooth_lag_feature_stream_tb;
  import dsl_pkg::*;

  localparam int DEPTH_RAW  = 9;
  localparam int DEPTH_DIFF = 16;
  localparam int DEPTH_WIN  = 16;
  localparam int SETTLE     = 600;
  localparam int CYCLE_CAP  = 1500000;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [32:0] value;
    logic [3:0]  elem;
    logic [15:0] win;
    logic        last;
  } feat_t;

  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] rw;
    logic        start;
  } row_t;

  logic        clk, rst;
  logic        push, full, empty, pop;
  logic [31:0] raw_value, rand_word;
  logic        series_start;
  logic [32:0] feature_value;
  logic [3:0]  element_index;
  logic [15:0] window_index;
  logic        window_last;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  diff_smooth_lag_feature_stream u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .raw_value(raw_value), .rand_word(rand_word), .series_start(series_start),
    .empty(empty), .pop(pop), .feature_value(feature_value),
    .element_index(element_index), .window_index(window_index),
    .window_last(window_last), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block's registers and series state
  int unsigned m_diff_lag, m_smooth_len, m_lag_count, m_cutoff, m_predict;
  longint      raw_hist[DEPTH_RAW];
  longint      diff_hist[DEPTH_DIFF];
  longint      smooth_hist[DEPTH_WIN];
  int unsigned n_samples, n_windows;
  bit          first_done;

  feat_t       pending_features[$];
  int          errors, items_sent, features_seen;
  int          cycles = 0;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout at %0t with %0d features pending", $time, pending_features.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic void clear_series();
    foreach (raw_hist[i]) raw_hist[i] = 0;
    foreach (diff_hist[i]) diff_hist[i] = 0;
    foreach (smooth_hist[i]) smooth_hist[i] = 0;
    n_samples = 0;
    n_windows = 0;
    first_done = 0;
  endfunction

  function automatic void shadow_config(logic [2:0] idx, logic [31:0] data);
    case (idx)
      CFG_DIFF_LAG:      m_diff_lag = 32'(data[3:0]);
      CFG_SMOOTH_LEN:    m_smooth_len = 32'(data[4:0]);
      CFG_LAG_COUNT:     m_lag_count = 32'(data[3:0]);
      CFG_SAMPLE_CUTOFF: m_cutoff = data;
      CFG_PREDICT_MODE:  m_predict = 32'(data[0]);
      default: ;
    endcase
  endfunction

  // works out the window elements caused by one accepted item
  function automatic void predict_features(row_t r);
    longint      x, d, span, mean;
    int unsigned dl, sl, wl, diffs;
    bit          have_d, emit;
    feat_t       f;
    x = longint'(signed'(r.raw));
    if (r.start) clear_series();
    dl = (m_diff_lag > 8) ? 8 : m_diff_lag;
    sl = (m_smooth_len == 0) ? 1 : ((m_smooth_len > 16) ? 16 : m_smooth_len);
    wl = (m_lag_count + 1 > 16) ? 16 : m_lag_count + 1;
    have_d = n_samples >= dl;
    d = (dl == 0) ? x : x - raw_hist[dl - 1];
    for (int i = DEPTH_RAW - 1; i > 0; i--) raw_hist[i] = raw_hist[i - 1];
    raw_hist[0] = x;
    if (n_samples < 16'hFFFF) n_samples++;
    if (!have_d) return;
    for (int i = DEPTH_DIFF - 1; i > 0; i--) diff_hist[i] = diff_hist[i - 1];
    diff_hist[0] = d;
    diffs = n_samples - dl;
    if (diffs < sl) return;
    span = 0;
    for (int i = 0; i < sl; i++) span += diff_hist[i];
    mean = span / longint'(sl);
    for (int i = DEPTH_WIN - 1; i > 0; i--) smooth_hist[i] = smooth_hist[i - 1];
    smooth_hist[0] = mean;
    if (diffs - sl + 1 < wl) return;
    if (m_predict != 0) begin
      emit = !first_done;
      first_done = 1;
    end else begin
      emit = r.rw <= m_cutoff;
    end
    if (emit) begin
      for (int i = 0; i < wl; i++) begin
        f.value = 33'(smooth_hist[wl - 1 - i]);
        f.elem  = 4'(i);
        f.win   = n_windows[15:0];
        f.last  = (i + 1 == wl);
        pending_features.push_back(f);
      end
    end
    if (n_windows < 16'hFFFF) n_windows++;
  endfunction

  // result side: stall pattern changes every so often
  initial begin
    int    mode, left;
    feat_t want;
    pop = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 120);
      end
      left--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 1);
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= ($urandom_range(0, 3) != 0);
      endcase
      @(posedge clk);
      if (!rst && pop && !empty) begin
        features_seen++;
        if (pending_features.size() == 0) begin
          $display("%0t: unexpected feature %h elem %0d win %0d last %0b", $time,
                   feature_value, element_index, window_index, window_last);
          errors++;
        end else begin
          want = pending_features.pop_front();
          if (want.value !== feature_value) begin
            $display("%0t: feature_value exp %h got %h", $time, want.value, feature_value);
            errors++;
          end
          if (want.elem !== element_index) begin
            $display("%0t: element_index exp %0d got %0d", $time, want.elem, element_index);
            errors++;
          end
          if (want.win !== window_index) begin
            $display("%0t: window_index exp %0d got %0d", $time, want.win, window_index);
            errors++;
          end
          if (want.last !== window_last) begin
            $display("%0t: window_last exp %0b got %0b", $time, want.last, window_last);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    shadow_config(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // block is idle once all features are out and the back end has finished
  task automatic wait_idle();
    wait (pending_features.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // holds push until the item is taken, then maybe opens a gap
  task automatic send_item(row_t r);
    @(negedge clk);
    push = 1'b1;
    raw_value = r.raw;
    rand_word = r.rw;
    series_start = r.start;
    do @(posedge clk); while (full);
    predict_features(r);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      @(negedge clk);
      push = 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  function automatic row_t random_row(bit new_series);
    row_t r;
    case ($urandom_range(0, 5))
      0: r.raw = $urandom_range(0, 255) - 128;
      1: r.raw = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: r.raw = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: r.rw = 32'h0;
      1: r.rw = 32'hFFFF_FFFF;
      default: r.rw = $urandom;
    endcase
    r.start = new_series || ($urandom_range(0, 39) == 0);
    return r;
  endfunction

  row_t directed[13] = '{
    '{32'h0000_0100, 32'h0, 1'b1},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{32'h8000_0000, 32'h0, 1'b0},
    '{32'h7FFF_FFFF, 32'h1234_5678, 1'b0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0},
    '{32'hFFFF_FFFF, 32'h0, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_0001, 32'h5555_5555, 1'b0},
    '{32'hFFFF_FF00, 32'hAAAA_AAAA, 1'b0},
    '{32'h7FFF_FFFF, 32'h0, 1'b0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_0300, 32'h0, 1'b1},
    '{32'hFFFF_FD00, 32'h0, 1'b0}
  };

  initial begin
    int unsigned settings[8][5];
    rst = 1'b1;
    push = 1'b0;
    raw_value = '0;
    rand_word = '0;
    series_start = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    features_seen = 0;
    burst_left = 0;
    m_diff_lag = 1;
    m_smooth_len = 3;
    m_lag_count = 5;
    m_cutoff = 32'hFFFF_FFFF;
    m_predict = 0;
    clear_series();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings first, then the simplest pass-through, then predict mode on a short run
    foreach (directed[i]) send_item(directed[i]);
    @(negedge clk) push = 1'b0;
    wait_idle();
    write_reg(CFG_DIFF_LAG, 0);
    write_reg(CFG_SMOOTH_LEN, 0);
    write_reg(CFG_LAG_COUNT, 0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    foreach (directed[i]) send_item(directed[i]);
    @(negedge clk) push = 1'b0;
    wait_idle();
    write_reg(CFG_SAMPLE_CUTOFF, 32'h1234_5678);
    write_reg(CFG_PREDICT_MODE, 1);
    foreach (directed[i]) if (i < 4) send_item(directed[i]);

    // diff_lag, smooth_len, lag_count, cutoff, predict; oversized values included
    settings = '{
      '{1, 3, 5, 32'hFFFF_FFFF, 0},
      '{8, 16, 15, 32'h8000_0000, 0},
      '{15, 31, 15, 32'h0, 0},
      '{0, 1, 0, 32'hFFFF_FFFF, 0},
      '{3, 0, 7, 32'hC000_0000, 1},
      '{9, 17, 2, 32'h4000_0000, 0},
      '{2, 5, 3, 32'hFFFF_FFFF, 1},
      '{5, 8, 11, 32'hFFFF_FFFF, 0}
    };
    for (int p = 0; p < 8; p++) begin
      @(negedge clk) push = 1'b0;
      wait_idle();
      write_reg(CFG_DIFF_LAG, settings[p][0]);
      write_reg(CFG_SMOOTH_LEN, settings[p][1]);
      write_reg(CFG_LAG_COUNT, settings[p][2]);
      write_reg(CFG_SAMPLE_CUTOFF, settings[p][3]);
      write_reg(CFG_PREDICT_MODE, settings[p][4]);
      for (int k = 0; k < 46; k++) begin
        send_item(random_row(k == 0 && p != 5));
        if (p == 3 && k == 20) begin
          // hold the sender until every feature has drained
          @(negedge clk) push = 1'b0;
          wait (pending_features.size() == 0);
        end
      end
    end
    @(negedge clk) push = 1'b0;
    wait_idle();

    $display("sent %0d items over %0d register settings, checked %0d window elements",
             items_sent, 11, features_seen);
    if (errors == 0 && pending_features.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d features missing", errors, pending_features.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/dsl_pkg.sv
design/dsl_cmd_fifo.sv
design/dsl_front.sv
design/dsl_back.sv
design/diff_smooth_lag_feature_stream.sv
verif/diff_smooth_lag_feature_stream_tb.sv
